FILE: hw/rtl/bcpe_pkg.sv
// Shared constants, types and register codes for the cubic Bezier point evaluator.
package bcpe_pkg;

   // Number of curve segments; must be a power of two from 2 to 4096.
   localparam int STEPS      = 256;
   localparam int LOG2_STEPS = $clog2(STEPS);

   localparam int STEP_W  = 9;
   localparam int COORD_W = 12;
   localparam int OUT_W   = 20;
   localparam int FRAC_W  = 8;

   // Clamped step index and its complement both lie in 0..STEPS.
   localparam int K_W   = LOG2_STEPS + 1;
   localparam int CMP_W = (K_W > STEP_W) ? K_W : STEP_W;
   localparam int WGT_W = K_W + 1;

   // Each de Casteljau level scales the coordinates by STEPS.
   localparam int LVL1_W = COORD_W + LOG2_STEPS;
   localparam int LVL2_W = COORD_W + 2 * LOG2_STEPS;
   localparam int LVL3_W = COORD_W + 3 * LOG2_STEPS;
   localparam int SHIFT  = 3 * LOG2_STEPS;

   localparam logic [CMP_W-1:0] STEPS_CMP = CMP_W'(STEPS);
   localparam logic [K_W-1:0]   STEPS_K   = K_W'(STEPS);

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_P0_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_P0_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_P1_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_P1_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_P2_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_P2_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_P3_X = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_P3_Y = 3'd7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [LVL1_W-1:0]  lvl1_type;
   typedef logic signed [LVL2_W-1:0]  lvl2_type;
   typedef logic signed [LVL3_W-1:0]  lvl3_type;
   typedef logic        [K_W-1:0]     step_type;

   localparam coord_type RST_P0_X = 12'sd20;
   localparam coord_type RST_P0_Y = 12'sd100;
   localparam coord_type RST_P1_X = 12'sd30;
   localparam coord_type RST_P1_Y = 12'sd120;
   localparam coord_type RST_P2_X = 12'sd50;
   localparam coord_type RST_P2_Y = 12'sd80;
   localparam coord_type RST_P3_X = 12'sd60;
   localparam coord_type RST_P3_Y = 12'sd100;

   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p3_x;
      coord_type p3_y;
   } ctrl_pts_type;

endpackage

FILE: hw/rtl/cubic_bezier_point_evaluator.sv
// Top level of the cubic Bezier point evaluator: CSR file, pipeline and output stage.
//
// Usage: the four control points P0..P3 (12-bit signed integers) are written through
// the csr_ port, register index 0..7 in the order p0_x, p0_y, p1_x, ... p3_y, one
// write per cycle with no wait. The user makes writes only while no beat is in flight; the block does not enforce this.
// Each beat on the req_ channel carries a step index k; t = k / STEPS, and a k
// above STEPS is treated as STEPS. Each beat yields exactly one rsp_ beat with
// the curve point (x, y) in two's complement with 8 fraction bits, rounded
// toward minus infinity.
// The accepting edge of a request loads the clamp stage; the three de Casteljau
// interpolation stages and the output register follow in that order, and
// rsp_valid rises when the output register loads the point.
// The block takes one point per cycle while rsp_ready is high; each interpolation
// stage holds one multiply-add level, which sets the clock period.
// When the receiver holds rsp_ready low, the output register keeps its point,
// the stages behind it fill up, and req_ready falls only once every stage holds
// a beat; nothing is dropped or repeated. Reset empties the pipeline and loads
// the default control points (20,100), (30,120), (50,80), (60,100).
module cubic_bezier_point_evaluator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bcpe_pkg::STEP_W-1:0]          req_step_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bcpe_pkg::OUT_W-1:0]    rsp_point_x,
   output logic signed [bcpe_pkg::OUT_W-1:0]    rsp_point_y,
   input  logic                                 csr_wr_en,
   input  logic [bcpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bcpe_pkg::COORD_W-1:0]         csr_wdata
);
   import bcpe_pkg::*;

   ctrl_pts_type pts;

   logic     core_valid;
   logic     core_ready;
   lvl3_type core_x;
   lvl3_type core_y;

   // Scaled sum shifted up by the fraction bits, then down by STEPS cubed.
   logic signed [LVL3_W+FRAC_W-1:0] x_scaled;
   logic signed [LVL3_W+FRAC_W-1:0] y_scaled;
   logic signed [LVL3_W+FRAC_W-1:0] x_shr;
   logic signed [LVL3_W+FRAC_W-1:0] y_shr;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_x_ff, rsp_x_in;
   logic signed [OUT_W-1:0]  rsp_y_ff, rsp_y_in;
   logic                     ld_out;

   bcpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pts       (pts)
   );

   bcpe_core u_core (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_step_index (req_step_index),
      .pts           (pts),
      .out_valid     (core_valid),
      .out_ready     (core_ready),
      .out_x         (core_x),
      .out_y         (core_y)
   );

   // The output register loads when empty or when its point is being taken.
   assign ld_out     = !rsp_valid_ff || rsp_ready;
   assign core_ready = ld_out;

   // The arithmetic shift is a floor division by STEPS cubed, since STEPS is a
   // power of two. The result is a convex combination of the control points, so
   // it always fits the output width.
   assign x_scaled = {core_x, FRAC_W'(0)};
   assign y_scaled = {core_y, FRAC_W'(0)};
   assign x_shr    = x_scaled >>> SHIFT;
   assign y_shr    = y_scaled >>> SHIFT;

   always_comb begin
      rsp_valid_in = ld_out ? core_valid : rsp_valid_ff;
      rsp_x_in     = ld_out ? x_shr[OUT_W-1:0] : rsp_x_ff;
      rsp_y_in     = ld_out ? y_shr[OUT_W-1:0] : rsp_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;

endmodule

FILE: hw/rtl/bcpe_csr.sv
// Control point register file written through the CSR port.
module bcpe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bcpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bcpe_pkg::COORD_W-1:0]       csr_wdata,
   output bcpe_pkg::ctrl_pts_type             pts
);
   import bcpe_pkg::*;

   ctrl_pts_type pts_ff;
   ctrl_pts_type pts_in;

   always_comb begin
      pts_in = pts_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_P0_X: pts_in.p0_x = csr_wdata;
            REG_P0_Y: pts_in.p0_y = csr_wdata;
            REG_P1_X: pts_in.p1_x = csr_wdata;
            REG_P1_Y: pts_in.p1_y = csr_wdata;
            REG_P2_X: pts_in.p2_x = csr_wdata;
            REG_P2_Y: pts_in.p2_y = csr_wdata;
            REG_P3_X: pts_in.p3_x = csr_wdata;
            REG_P3_Y: pts_in.p3_y = csr_wdata;
            default:  pts_in = pts_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff.p0_x <= RST_P0_X;
         pts_ff.p0_y <= RST_P0_Y;
         pts_ff.p1_x <= RST_P1_X;
         pts_ff.p1_y <= RST_P1_Y;
         pts_ff.p2_x <= RST_P2_X;
         pts_ff.p2_y <= RST_P2_Y;
         pts_ff.p3_x <= RST_P3_X;
         pts_ff.p3_y <= RST_P3_Y;
      end else begin
         pts_ff <= pts_in;
      end
   end

   assign pts = pts_ff;

endmodule

FILE: hw/rtl/bcpe_core.sv
// Four-stage pipeline: step clamp and three de Casteljau interpolation levels.
module bcpe_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bcpe_pkg::STEP_W-1:0]   in_step_index,
   input  bcpe_pkg::ctrl_pts_type        pts,
   output logic                          out_valid,
   input  logic                          out_ready,
   output bcpe_pkg::lvl3_type            out_x,
   output bcpe_pkg::lvl3_type            out_y
);
   import bcpe_pkg::*;

   // Scaled interpolation a*(STEPS-k) + b*k; the sum is exact at the result width.
   function automatic lvl1_type lerp1(input coord_type a, input coord_type b,
                                      input step_type m, input step_type k);
      logic signed [COORD_W+WGT_W:0] sum;
      sum = a * $signed({1'b0, m}) + b * $signed({1'b0, k});
      return sum[LVL1_W-1:0];
   endfunction

   function automatic lvl2_type lerp2(input lvl1_type a, input lvl1_type b,
                                      input step_type m, input step_type k);
      logic signed [LVL1_W+WGT_W:0] sum;
      sum = a * $signed({1'b0, m}) + b * $signed({1'b0, k});
      return sum[LVL2_W-1:0];
   endfunction

   function automatic lvl3_type lerp3(input lvl2_type a, input lvl2_type b,
                                      input step_type m, input step_type k);
      logic signed [LVL2_W+WGT_W:0] sum;
      sum = a * $signed({1'b0, m}) + b * $signed({1'b0, k});
      return sum[LVL3_W-1:0];
   endfunction

   logic ld1, ld2, ld3, ld4;

   logic     v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   step_type k1_ff, k1_in, m1_ff, m1_in;
   step_type k2_ff, k2_in, m2_ff, m2_in;
   step_type k3_ff, k3_in, m3_ff, m3_in;
   lvl1_type q_x_ff [3];
   lvl1_type q_x_in [3];
   lvl1_type q_y_ff [3];
   lvl1_type q_y_in [3];
   lvl2_type r_x_ff [2];
   lvl2_type r_x_in [2];
   lvl2_type r_y_ff [2];
   lvl2_type r_y_in [2];
   lvl3_type b_x_ff, b_x_in, b_y_ff, b_y_in;

   logic [CMP_W-1:0] step_ext;
   logic [CMP_W-1:0] step_clamp;

   // A stage takes new data when it is empty or its content moves on.
   assign ld4      = !v4_ff || out_ready;
   assign ld3      = !v3_ff || ld4;
   assign ld2      = !v2_ff || ld3;
   assign ld1      = !v1_ff || ld2;
   assign in_ready = ld1;

   // Steps past the end of the curve are pinned to t = 1.
   assign step_ext   = CMP_W'(in_step_index);
   assign step_clamp = (step_ext > STEPS_CMP) ? STEPS_CMP : step_ext;

   always_comb begin
      v1_in = ld1 ? in_valid : v1_ff;
      k1_in = ld1 ? step_clamp[K_W-1:0] : k1_ff;
      m1_in = ld1 ? STEPS_K - step_clamp[K_W-1:0] : m1_ff;

      v2_in = ld2 ? v1_ff : v2_ff;
      k2_in = ld2 ? k1_ff : k2_ff;
      m2_in = ld2 ? m1_ff : m2_ff;
      q_x_in[0] = ld2 ? lerp1(pts.p0_x, pts.p1_x, m1_ff, k1_ff) : q_x_ff[0];
      q_y_in[0] = ld2 ? lerp1(pts.p0_y, pts.p1_y, m1_ff, k1_ff) : q_y_ff[0];
      q_x_in[1] = ld2 ? lerp1(pts.p1_x, pts.p2_x, m1_ff, k1_ff) : q_x_ff[1];
      q_y_in[1] = ld2 ? lerp1(pts.p1_y, pts.p2_y, m1_ff, k1_ff) : q_y_ff[1];
      q_x_in[2] = ld2 ? lerp1(pts.p2_x, pts.p3_x, m1_ff, k1_ff) : q_x_ff[2];
      q_y_in[2] = ld2 ? lerp1(pts.p2_y, pts.p3_y, m1_ff, k1_ff) : q_y_ff[2];

      v3_in = ld3 ? v2_ff : v3_ff;
      k3_in = ld3 ? k2_ff : k3_ff;
      m3_in = ld3 ? m2_ff : m3_ff;
      for (int i = 0; i < 2; i++) begin
         r_x_in[i] = ld3 ? lerp2(q_x_ff[i], q_x_ff[i+1], m2_ff, k2_ff) : r_x_ff[i];
         r_y_in[i] = ld3 ? lerp2(q_y_ff[i], q_y_ff[i+1], m2_ff, k2_ff) : r_y_ff[i];
      end

      v4_in  = ld4 ? v3_ff : v4_ff;
      b_x_in = ld4 ? lerp3(r_x_ff[0], r_x_ff[1], m3_ff, k3_ff) : b_x_ff;
      b_y_in = ld4 ? lerp3(r_y_ff[0], r_y_ff[1], m3_ff, k3_ff) : b_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff  <= k1_in;
      m1_ff  <= m1_in;
      k2_ff  <= k2_in;
      m2_ff  <= m2_in;
      k3_ff  <= k3_in;
      m3_ff  <= m3_in;
      q_x_ff <= q_x_in;
      q_y_ff <= q_y_in;
      r_x_ff <= r_x_in;
      r_y_ff <= r_y_in;
      b_x_ff <= b_x_in;
      b_y_ff <= b_y_in;
   end

   assign out_valid = v4_ff;
   assign out_x     = b_x_ff;
   assign out_y     = b_y_ff;

   // The input side only stalls when every stage holds a beat.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled while the pipeline has a bubble");

   // The two interpolation weights always sum to the step count.
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ((K_W+1)'(k1_ff) + (K_W+1)'(m1_ff) == (K_W+1)'(STEPS)))
      else $error("step weights do not sum to STEPS");

   // A stalled last stage keeps its point.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !out_ready) |=> (v4_ff && $stable(b_x_ff) && $stable(b_y_ff)))
      else $error("last stage changed while stalled");

   // A beat in stage three moves on or stays; it never vanishes.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !ld4) |=> (v3_ff && v4_ff))
      else $error("beat lost between stages three and four");

endmodule
